// ----- hdl/slrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slrs_pkg
// shared sizes, request codes and inter-module structs of the ring log store
// ----------------------------------------------------------------------------
package slrs_pkg;

  localparam int KINDS      = 4;
  localparam int SLOTS      = 16;
  localparam int SLOT_BYTES = 32;

  localparam int KIND_W      = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int BYTE_W      = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int OFF_W       = $clog2(SLOT_BYTES + 1);
  localparam int SEQ_W       = 16;
  localparam int MASK_W      = 4;
  localparam int SEQ_DEPTH   = KINDS * SLOTS;
  localparam int SEQ_AW      = $clog2(SEQ_DEPTH);
  localparam int ENTRY_DEPTH = KINDS * SLOTS * SLOT_BYTES;
  localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DISABLED = 1'b1;

  // clearing sweep after reset
  typedef struct packed {
    logic                active;
    logic [ENTRY_AW-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic              start;
    logic [KIND_W-1:0] kind;
  } head_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] head;
    logic [SEQ_W-1:0]  next_seq;
  } head_rsp_t;

  typedef struct packed {
    logic              en;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  data;
  } seq_wr_t;

  typedef struct packed {
    logic              en;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] off;
  } entry_acc_t;

endpackage
`default_nettype wire

// ----- hdl/sequenced_ring_log_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequenced_ring_log_store
// per-kind rings of byte slots stamped with 16-bit sequence words; init,
// byte-streamed write and read of the entry a given number of writes back
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  config  | cfg_wr_en             | cfg_wr_data (enable_mask, 4 bits)
//  input   | in_valid / in_ready   | req_type log_kind data_byte last_byte
//          |                       | entries_back read_len
//  output  | out_valid / out_ready | is_data status read_byte last_out
//
// after reset a clearing sweep zeroes both stores, one byte address a cycle:
//   KINDS*SLOTS*SLOT_BYTES = 2048 addresses, with in_ready low (config still taken)
// one item at a time; the head walk reads one sequence word a cycle through the
//   sequence memory read port, from slot 0 until the run of consecutive words ends
// write byte: S_IDLE then S_WR_BYTE, the committing byte also passes S_EMIT;
//   a head search comes first on the first byte of an entry
// read: one head search, then S_RD_ISSUE and S_RD_WAIT per byte through the entry memory
// init: one head search per kind; results wait in the output register
//
module sequenced_ring_log_store (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [1:0]  log_kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] entries_back,
  input  wire logic [7:0]  read_len,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_data,
  output logic             status,
  output logic [7:0]       read_byte,
  output logic             last_out
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_HEAD     = 7'b0000100,
    S_WR_BYTE  = 7'b0001000,
    S_RD_ISSUE = 7'b0010000,
    S_RD_WAIT  = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [slrs_pkg::MASK_W-1:0]   enable_mask;
  logic [slrs_pkg::ENTRY_AW-1:0] clr_addr;

  // latched item
  slrs_pkg::req_t                req_op;
  logic [1:0]                    req_kind;
  logic [7:0]                    req_data;
  logic                          req_last;
  logic [15:0]                   req_back;
  logic [slrs_pkg::OFF_W-1:0]    req_n;
  logic                          rd_bad;
  logic [slrs_pkg::SLOT_W-1:0]   rd_slot;
  logic [slrs_pkg::OFF_W-1:0]    rd_idx;
  logic [slrs_pkg::KIND_W-1:0]   init_kind;
  logic                          emit_status;

  // open write
  logic [slrs_pkg::SLOT_W-1:0]   write_slot;
  logic [slrs_pkg::SEQ_W-1:0]    write_seq;
  logic [slrs_pkg::OFF_W-1:0]    write_offset;
  logic                          write_open;
  logic                          write_open_next;

  slrs_pkg::clr_t                clr;
  slrs_pkg::head_req_t           head_req;
  slrs_pkg::head_rsp_t           head_rsp;
  slrs_pkg::seq_wr_t             seq_wr;
  slrs_pkg::entry_acc_t          entry_wr;
  slrs_pkg::entry_acc_t          entry_rd;
  logic [7:0]                    entry_rdata;

  logic                          accept;
  logic                          in_bad_kind;
  logic                          in_disabled;
  logic [slrs_pkg::OFF_W-1:0]    len_clamp;
  logic [slrs_pkg::KIND_W-1:0]   in_kind_k;
  logic [slrs_pkg::KIND_W-1:0]   req_kind_k;
  logic                          out_free;
  logic                          out_load;
  logic                          rd_last;
  logic                          wr_room;
  logic [slrs_pkg::SLOT_W-1:0]   back_s;
  logic [slrs_pkg::SLOT_W-1:0]   read_slot;
  logic [slrs_pkg::SLOT_W-1:0]   next_slot;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign in_bad_kind = (int'(log_kind) >= slrs_pkg::KINDS);
  assign in_disabled = in_bad_kind || !enable_mask[log_kind];
  assign len_clamp   = (int'(read_len) < slrs_pkg::SLOT_BYTES) ?
                       slrs_pkg::OFF_W'(read_len) : slrs_pkg::OFF_W'(slrs_pkg::SLOT_BYTES);
  assign in_kind_k   = slrs_pkg::KIND_W'(log_kind);
  assign req_kind_k  = slrs_pkg::KIND_W'(req_kind);
  assign out_free    = !out_valid || out_ready;
  assign rd_last     = ((rd_idx + slrs_pkg::OFF_W'(1)) == req_n);
  assign wr_room     = (int'(write_offset) < slrs_pkg::SLOT_BYTES);

  // read target: head minus entries_back around the ring, far look-backs read the head
  assign back_s    = (int'(req_back) < slrs_pkg::SLOTS) ?
                     slrs_pkg::SLOT_W'(req_back) : '0;
  assign read_slot = (head_rsp.head >= back_s) ? head_rsp.head - back_s :
                     head_rsp.head + slrs_pkg::SLOT_W'(slrs_pkg::SLOTS) - back_s;
  // new entry goes one past the head
  assign next_slot = (head_rsp.head == slrs_pkg::SLOT_W'(slrs_pkg::SLOTS - 1)) ?
                     '0 : head_rsp.head + slrs_pkg::SLOT_W'(1);

  assign clr.active = (state == S_CLEAR);
  assign clr.addr   = clr_addr;

  always_comb begin
    state_next      = state;
    write_open_next = write_open;
    out_load        = 1'b0;
    head_req        = '0;
    seq_wr          = '0;
    entry_wr        = '0;
    entry_rd        = '0;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == slrs_pkg::ENTRY_AW'(slrs_pkg::ENTRY_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (slrs_pkg::req_t'(req_type))
            slrs_pkg::REQ_INIT: begin
              write_open_next = 1'b0;
              head_req.start  = 1'b1;
              head_req.kind   = '0;
              state_next      = S_HEAD;
            end
            slrs_pkg::REQ_WRITE: begin
              if (in_disabled) begin
                // refused byte closes any open write
                write_open_next = 1'b0;
                state_next      = last_byte ? S_EMIT : S_IDLE;
              end else if (!write_open) begin
                head_req.start = 1'b1;
                head_req.kind  = in_kind_k;
                state_next     = S_HEAD;
              end else begin
                state_next = S_WR_BYTE;
              end
            end
            slrs_pkg::REQ_READ: begin
              if (len_clamp == '0) begin
                state_next = S_EMIT;
              end else if (in_bad_kind) begin
                state_next = S_RD_ISSUE;
              end else begin
                head_req.start = 1'b1;
                head_req.kind  = in_kind_k;
                state_next     = S_HEAD;
              end
            end
            slrs_pkg::REQ_NONE: begin
              state_next = S_IDLE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_HEAD: begin
        if (head_rsp.done) begin
          unique case (req_op)
            slrs_pkg::REQ_INIT: begin
              // rings whose head sits at slot 0 restart at sequence 0
              if (head_rsp.head == '0) begin
                seq_wr.en   = 1'b1;
                seq_wr.kind = init_kind;
                seq_wr.slot = '0;
                seq_wr.data = '0;
              end
              if (init_kind == slrs_pkg::KIND_W'(slrs_pkg::KINDS - 1)) begin
                state_next = S_EMIT;
              end else begin
                head_req.start = 1'b1;
                head_req.kind  = init_kind + slrs_pkg::KIND_W'(1);
              end
            end
            slrs_pkg::REQ_WRITE: begin
              write_open_next = 1'b1;
              state_next      = S_WR_BYTE;
            end
            slrs_pkg::REQ_READ: begin
              state_next = S_RD_ISSUE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_WR_BYTE: begin
        // bytes past the slot are dropped; each byte lands in its own kind's ring
        entry_wr.en   = wr_room;
        entry_wr.kind = req_kind_k;
        entry_wr.slot = write_slot;
        entry_wr.off  = write_offset[slrs_pkg::BYTE_W-1:0];
        if (req_last) begin
          seq_wr.en       = 1'b1;
          seq_wr.kind     = req_kind_k;
          seq_wr.slot     = write_slot;
          seq_wr.data     = write_seq;
          write_open_next = 1'b0;
          state_next      = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        entry_rd.en   = !rd_bad;
        entry_rd.kind = req_kind_k;
        entry_rd.slot = rd_slot;
        entry_rd.off  = rd_idx[slrs_pkg::BYTE_W-1:0];
        state_next    = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = rd_last ? S_IDLE : S_RD_ISSUE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      enable_mask  <= 4'hF;
      write_open   <= 1'b0;
      write_offset <= '0;
      out_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      write_open <= write_open_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + slrs_pkg::ENTRY_AW'(1);
      end
      if (cfg_wr_en) begin
        enable_mask <= cfg_wr_data;
      end
      if ((state == S_HEAD) && head_rsp.done && (req_op == slrs_pkg::REQ_WRITE)) begin
        write_offset <= '0;
      end else if ((state == S_WR_BYTE) && wr_room) begin
        write_offset <= write_offset + slrs_pkg::OFF_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op      <= slrs_pkg::req_t'(req_type);
      req_kind    <= log_kind;
      req_data    <= data_byte;
      req_last    <= last_byte;
      req_back    <= entries_back;
      req_n       <= len_clamp;
      rd_bad      <= in_bad_kind;
      rd_idx      <= '0;
      rd_slot     <= '0;
      init_kind   <= '0;
      emit_status <= ((slrs_pkg::req_t'(req_type) == slrs_pkg::REQ_WRITE) && in_disabled) ?
                     slrs_pkg::STATUS_DISABLED : slrs_pkg::STATUS_OK;
    end
    if ((state == S_HEAD) && head_rsp.done) begin
      if (req_op == slrs_pkg::REQ_INIT) begin
        init_kind <= init_kind + slrs_pkg::KIND_W'(1);
      end
      if (req_op == slrs_pkg::REQ_WRITE) begin
        write_slot <= next_slot;
        write_seq  <= head_rsp.next_seq;
      end
      if (req_op == slrs_pkg::REQ_READ) begin
        rd_slot <= read_slot;
      end
    end
    if ((state == S_RD_WAIT) && out_free) begin
      rd_idx <= rd_idx + slrs_pkg::OFF_W'(1);
    end
    if (out_load) begin
      if (state == S_RD_WAIT) begin
        is_data   <= 1'b1;
        status    <= slrs_pkg::STATUS_OK;
        read_byte <= rd_bad ? 8'h00 : entry_rdata;
        last_out  <= rd_last;
      end else begin
        is_data   <= 1'b0;
        status    <= emit_status;
        read_byte <= 8'h00;
        last_out  <= 1'b1;
      end
    end
  end

  slrs_seq_store u_seq_store (
    .clk (clk),
    .rst (rst),
    .clr (clr),
    .wr  (seq_wr),
    .req (head_req),
    .rsp (head_rsp)
  );

  slrs_entry_store u_entry_store (
    .clk     (clk),
    .clr     (clr),
    .wr      (entry_wr),
    .wr_data (req_data),
    .rd      (entry_rd),
    .rd_data (entry_rdata)
  );

  // write offset never runs past the slot
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    int'(write_offset) <= slrs_pkg::SLOT_BYTES)
    else $error("write offset beyond slot size");

  // the committing byte always closes the write
  a_commit_closes: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WR_BYTE) && req_last) |=> !write_open)
    else $error("write still open after commit");

  // a read never fetches past the requested count
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_ISSUE) |-> (rd_idx < req_n))
    else $error("read index beyond byte count");

  // the head walker is only started when it is free
  a_head_free: assert property (@(posedge clk) disable iff (rst)
    head_req.start |-> ((state == S_IDLE) || head_rsp.done))
    else $error("head search started while busy");

endmodule
`default_nettype wire

// ----- hdl/slrs_seq_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slrs_seq_store
// sequence word memory with the head walker (one shared increment/compare)
// ----------------------------------------------------------------------------
module slrs_seq_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire slrs_pkg::clr_t      clr,
  input  wire slrs_pkg::seq_wr_t   wr,
  input  wire slrs_pkg::head_req_t req,
  output slrs_pkg::head_rsp_t      rsp
);

  typedef enum logic [3:0] {
    H_IDLE  = 4'b0001,
    H_FIRST = 4'b0010,
    H_WALK  = 4'b0100,
    H_WRAP  = 4'b1000
  } hstate_t;

  function automatic logic [slrs_pkg::SEQ_AW-1:0] seq_addr(
    input logic [slrs_pkg::KIND_W-1:0] kind,
    input logic [slrs_pkg::SLOT_W-1:0] slot
  );
    return slrs_pkg::SEQ_AW'(int'(kind) * slrs_pkg::SLOTS + int'(slot));
  endfunction

  logic [slrs_pkg::SEQ_W-1:0]  mem [slrs_pkg::SEQ_DEPTH];
  logic [slrs_pkg::SEQ_W-1:0]  rdata;
  logic [slrs_pkg::SEQ_W-1:0]  prev;
  logic [slrs_pkg::SEQ_W-1:0]  inc;
  logic [slrs_pkg::SLOT_W-1:0] step;
  logic [slrs_pkg::SLOT_W-1:0] rd_slot;
  logic [slrs_pkg::KIND_W-1:0] kind_q;
  logic [slrs_pkg::KIND_W-1:0] kind_sel;
  logic [slrs_pkg::SLOT_W-1:0] head_q;
  logic [slrs_pkg::SEQ_W-1:0]  seq_q;
  logic                        done_q;
  logic                        rd_en;
  logic                        run_end;
  logic                        clr_hit;
  hstate_t                     state;
  hstate_t                     state_next;

  // the one shared unit: previous word plus one, compared with the new word
  assign inc      = prev + slrs_pkg::SEQ_W'(1);
  assign run_end  = (rdata != inc);
  assign kind_sel = (state == H_IDLE) ? req.kind : kind_q;
  assign clr_hit  = clr.active &&
                    ({1'b0, clr.addr} < (slrs_pkg::ENTRY_AW + 1)'(slrs_pkg::SEQ_DEPTH));

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_slot    = '0;
    unique case (state)
      H_IDLE: begin
        if (req.start) begin
          rd_en      = 1'b1;
          state_next = H_FIRST;
        end
      end
      H_FIRST: begin
        rd_en      = 1'b1;
        rd_slot    = slrs_pkg::SLOT_W'(1);
        state_next = H_WALK;
      end
      H_WALK: begin
        if (run_end) begin
          state_next = H_IDLE;
        end else if (step == slrs_pkg::SLOT_W'(slrs_pkg::SLOTS - 1)) begin
          state_next = H_WRAP;
        end else begin
          rd_en   = 1'b1;
          rd_slot = (step == slrs_pkg::SLOT_W'(slrs_pkg::SLOTS - 2)) ?
                    '0 : step + slrs_pkg::SLOT_W'(2);
        end
      end
      H_WRAP: begin
        state_next = H_IDLE;
      end
      default: begin
        state_next = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= H_IDLE;
      done_q <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= ((state == H_WALK) && run_end) || (state == H_WRAP);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == H_IDLE) && req.start) begin
      kind_q <= req.kind;
    end
    if (state == H_FIRST) begin
      prev <= rdata;
      step <= '0;
    end
    if (state == H_WALK) begin
      prev <= rdata;
      step <= step + slrs_pkg::SLOT_W'(1);
      if (run_end) begin
        head_q <= step;
        seq_q  <= inc;
      end
    end
    // full circle: head is slot 0, prev now holds slot 0's word
    if (state == H_WRAP) begin
      head_q <= '0;
      seq_q  <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_hit) begin
      mem[clr.addr[slrs_pkg::SEQ_AW-1:0]] <= '0;
    end else if (wr.en) begin
      mem[seq_addr(wr.kind, wr.slot)] <= wr.data;
    end
    if (rd_en) begin
      rdata <= mem[seq_addr(kind_sel, rd_slot)];
    end
  end

  assign rsp.done     = done_q;
  assign rsp.head     = head_q;
  assign rsp.next_seq = seq_q;

endmodule
`default_nettype wire

// ----- hdl/slrs_entry_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slrs_entry_store
// slot byte memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module slrs_entry_store (
  input  wire logic                 clk,
  input  wire slrs_pkg::clr_t       clr,
  input  wire slrs_pkg::entry_acc_t wr,
  input  wire logic [7:0]           wr_data,
  input  wire slrs_pkg::entry_acc_t rd,
  output logic [7:0]                rd_data
);

  function automatic logic [slrs_pkg::ENTRY_AW-1:0] entry_addr(
    input slrs_pkg::entry_acc_t a
  );
    return slrs_pkg::ENTRY_AW'((int'(a.kind) * slrs_pkg::SLOTS + int'(a.slot)) *
                               slrs_pkg::SLOT_BYTES + int'(a.off));
  endfunction

  logic [7:0] mem [slrs_pkg::ENTRY_DEPTH];

  always_ff @(posedge clk) begin
    if (clr.active) begin
      mem[clr.addr] <= '0;
    end else if (wr.en) begin
      mem[entry_addr(wr)] <= wr_data;
    end
    if (rd.en) begin
      rd_data <= mem[entry_addr(rd)];
    end
  end

endmodule
`default_nettype wire

// ----- tb/sequenced_ring_log_store_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequenced_ring_log_store_tb
// drives init, byte-streamed write and read requests into the ring log store,
// predicts every result from a local copy of the rings and checks each
// accepted result in order, across several enable masks and idle/stall mixes
// ----------------------------------------------------------------------------
module sequenced_ring_log_store_tb;
  import slrs_pkg::*;

  // one input item as handed to the block
  typedef struct {
    req_t        req;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] back;
    logic [7:0]  len;
  } log_req_t;

  // one result item as it should leave the block
  typedef struct packed {
    logic       is_data;
    logic       status;
    logic [7:0] rd_byte;
    logic       last;
  } log_result_t;

  // pause after the last expected result, covers a head walk plus a byte write
  localparam int SETTLE_CYCLES = 64;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_wr_en    = 1'b0;
  logic [3:0]  cfg_wr_data  = 4'd0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type     = 2'd0;
  logic [1:0]  log_kind     = 2'd0;
  logic [7:0]  data_byte    = 8'd0;
  logic        last_byte    = 1'b0;
  logic [15:0] entries_back = 16'd0;
  logic [7:0]  read_len     = 8'd0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        is_data;
  logic        status;
  logic [7:0]  read_byte;
  logic        last_out;

  // stimulus backlog and results still owed by the block
  log_req_t    req_backlog[$];
  log_result_t results_due[$];
  log_req_t    in_flight;

  // idle and stall odds, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int mismatch_count = 0;
  int results_seen   = 0;

  // local copy of the rings and of the open write
  logic [15:0] seq_mem   [SEQ_DEPTH];
  logic [7:0]  entry_mem [ENTRY_DEPTH];
  logic [3:0]  enable_bits;
  int          wr_slot;
  logic [15:0] wr_seq;
  int          wr_off;
  bit          wr_open;

  sequenced_ring_log_store dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .log_kind     (log_kind),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .entries_back (entries_back),
    .read_len     (read_len),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_data      (is_data),
    .status       (status),
    .read_byte    (read_byte),
    .last_out     (last_out)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  // head of a ring: end of the run of consecutive sequence words from slot 0
  function automatic int ring_head(int k);
    logic [15:0] prev;
    logic [15:0] nxt;
    logic [15:0] step;
    prev = seq_mem[k * SLOTS];
    for (int i = 0; i < SLOTS; i++) begin
      nxt  = seq_mem[k * SLOTS + (i + 1) % SLOTS];
      step = prev + 16'd1;
      if (nxt != step) return i;
      prev = nxt;
    end
    return 0;
  endfunction

  function automatic void owe_result(logic d, logic st, logic [7:0] b, logic l);
    log_result_t r;
    r.is_data = d;
    r.status  = st;
    r.rd_byte = b;
    r.last    = l;
    results_due.push_back(r);
  endfunction

  // predicts the results of one accepted item and updates the local rings
  function automatic void predict_log_request(log_req_t it);
    int k;
    int head;
    int slot;
    int back;
    int n;
    logic [7:0] b;
    k = it.kind;
    case (it.req)
      REQ_INIT: begin
        // only rings whose head sits at slot 0 get slot 0 zeroed
        for (int j = 0; j < KINDS; j++)
          if (ring_head(j) == 0) seq_mem[j * SLOTS] = 16'd0;
        wr_open = 1'b0;
        owe_result(1'b0, STATUS_OK, 8'd0, 1'b1);
      end
      REQ_WRITE: begin
        if (k >= KINDS || !enable_bits[k]) begin
          // refused byte also drops any open write
          wr_open = 1'b0;
          if (it.last) owe_result(1'b0, STATUS_DISABLED, 8'd0, 1'b1);
        end else begin
          if (!wr_open) begin
            head    = ring_head(k);
            wr_slot = (head + 1) % SLOTS;
            wr_seq  = seq_mem[k * SLOTS + head] + 16'd1;
            wr_off  = 0;
            wr_open = 1'b1;
          end
          // bytes past the slot size are dropped
          if (wr_off < SLOT_BYTES) begin
            entry_mem[(k * SLOTS + wr_slot) * SLOT_BYTES + wr_off] = it.data;
            wr_off++;
          end
          if (it.last) begin
            seq_mem[k * SLOTS + wr_slot] = wr_seq;
            wr_open = 1'b0;
            owe_result(1'b0, STATUS_OK, 8'd0, 1'b1);
          end
        end
      end
      REQ_READ: begin
        n = (it.len < SLOT_BYTES) ? it.len : SLOT_BYTES;
        if (n == 0) begin
          owe_result(1'b0, STATUS_OK, 8'd0, 1'b1);
        end else begin
          slot = 0;
          if (k < KINDS) begin
            head = ring_head(k);
            back = it.back;
            if (back >= SLOTS) back = 0;
            slot = (head + SLOTS - back) % SLOTS;
          end
          for (int i = 0; i < n; i++) begin
            b = (k < KINDS) ? entry_mem[(k * SLOTS + slot) * SLOT_BYTES + i] : 8'd0;
            owe_result(1'b1, STATUS_OK, b, (i == n - 1));
          end
        end
      end
      default: begin
        // unknown request: no result, no state change
      end
    endcase
  endfunction

  task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_log_result();
    log_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result is_data=%0b status=%0b byte=%0h last=%0b",
                                is_data, status, read_byte, last_out));
    end else begin
      want = results_due.pop_front();
      cmp_field("is_data", 8'(is_data), 8'(want.is_data));
      cmp_field("status", 8'(status), 8'(want.status));
      cmp_field("read_byte", read_byte, want.rd_byte);
      cmp_field("last_out", 8'(last_out), 8'(want.last));
    end
    results_seen++;
  endtask

  // driver: holds valid and payload until taken, then loads the next item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_log_request(in_flight);
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = req_backlog.pop_front();
          in_valid     <= 1'b1;
          req_type     <= in_flight.req;
          log_kind     <= in_flight.kind;
          data_byte    <= in_flight.data;
          last_byte    <= in_flight.last;
          entries_back <= in_flight.back;
          read_len     <= in_flight.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every accepted result, stalls at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_log_result();
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void queue_req(req_t req, int kind, int data, int last, int back, int len);
    log_req_t it;
    it.req  = req;
    it.kind = kind[1:0];
    it.data = data[7:0];
    it.last = last[0];
    it.back = back[15:0];
    it.len  = len[7:0];
    req_backlog.push_back(it);
  endfunction

  // mask only changes while the block is idle
  task automatic write_enable_mask(logic [3:0] mask);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    enable_bits = mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every item is taken and every result is back, then let a
  // write byte that owes no result finish inside the block
  task automatic settle();
    @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_directed();
    queue_req(REQ_INIT, 0, 0, 0, 0, 1);
    // smallest and largest byte in one entry
    queue_req(REQ_WRITE, 0, 8'h00, 0, 0, 1);
    queue_req(REQ_WRITE, 0, 8'hFF, 1, 0, 1);
    queue_req(REQ_READ, 0, 0, 0, 0, 2);
    // out-of-range back count reads the newest, length clamps to the slot
    queue_req(REQ_READ, 0, 0, 0, 16'hFFFF, 255);
    queue_req(REQ_READ, 0, 0, 0, SLOTS, SLOT_BYTES + 1);
    queue_req(REQ_READ, 1, 0, 0, SLOTS - 1, 1);
    // empty read gives a bare status
    queue_req(REQ_READ, 2, 0, 0, 0, 0);
    // unknown request is ignored
    queue_req(REQ_NONE, 3, 8'hFF, 1, 16'hFFFF, 255);
    // kind changes mid-write: bytes land per kind, commit stamps the last kind
    queue_req(REQ_WRITE, 2, 8'hA5, 0, 0, 1);
    queue_req(REQ_WRITE, 3, 8'h5A, 1, 0, 1);
    queue_req(REQ_READ, 3, 0, 0, 0, 4);
    queue_req(REQ_READ, 2, 0, 0, 0, 2);
    // init closes an open write
    queue_req(REQ_WRITE, 1, 8'h3C, 0, 0, 1);
    queue_req(REQ_INIT, 1, 0, 0, 0, 1);
    queue_req(REQ_WRITE, 1, 8'hC3, 1, 0, 1);
    queue_req(REQ_READ, 1, 0, 0, 0, 3);
    queue_req(REQ_READ, 1, 0, 0, 1, 3);
    queue_req(REQ_WRITE, 0, 8'h80, 1, 0, 1);
    queue_req(REQ_READ, 0, 0, 0, 1, SLOT_BYTES);
  endtask

  // mostly well-formed writes of random content, reads and inits; some noise
  task automatic load_random(int n);
    int made;
    int r;
    int k;
    int nbytes;
    int odd_at;
    int back;
    int len;
    bit keep_open;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        // ring 0 gets over half the entries so it wraps around
        k = $urandom_range(1) ? 0 : $urandom_range(KINDS - 1);
        r = $urandom_range(99);
        nbytes = (r < 60) ? $urandom_range(1, 3) :
                 (r < 92) ? $urandom_range(4, 10) :
                            $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 8);
        keep_open = ($urandom_range(99) < 10);
        odd_at = ($urandom_range(99) < 8) ? $urandom_range(nbytes - 1) : -1;
        for (int i = 0; i < nbytes; i++)
          queue_req(REQ_WRITE, (i == odd_at) ? $urandom_range(KINDS - 1) : k,
                    $urandom_range(255), int'((i == nbytes - 1) && !keep_open),
                    $urandom_range(65535), $urandom_range(255));
        made += nbytes;
      end else if (r < 80) begin
        back = ($urandom_range(99) < 70) ? $urandom_range(SLOTS - 1) : $urandom_range(65535);
        r = $urandom_range(99);
        len = (r < 5)  ? 0 :
              (r < 70) ? $urandom_range(1, 8) :
              (r < 90) ? $urandom_range(1, 255) :
                         $urandom_range(SLOT_BYTES, SLOT_BYTES + 1);
        queue_req(REQ_READ, $urandom_range(KINDS - 1), $urandom_range(255),
                  $urandom_range(1), back, len);
        made++;
      end else if (r < 90) begin
        queue_req(REQ_INIT, $urandom_range(3), $urandom_range(255), $urandom_range(1),
                  $urandom_range(65535), $urandom_range(255));
        made++;
      end else if (r < 96) begin
        // stray write byte
        queue_req(REQ_WRITE, $urandom_range(3), $urandom_range(255), $urandom_range(1),
                  $urandom_range(65535), $urandom_range(255));
        made++;
      end else begin
        // ignored by the block, not counted
        queue_req(REQ_NONE, $urandom_range(3), $urandom_range(255), $urandom_range(1),
                  $urandom_range(65535), $urandom_range(255));
      end
    end
  endtask

  task automatic run_phase(logic [3:0] mask, int idle, int stall, int n_random);
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    write_enable_mask(mask);
    @(negedge clk);
    if (n_random == 0) load_directed();
    else load_random(n_random);
    settle();
  endtask

  initial begin
    // local rings start cleared, as the block's sweep leaves them
    foreach (seq_mem[i]) seq_mem[i] = 16'd0;
    foreach (entry_mem[i]) entry_mem[i] = 8'd0;
    enable_bits = 4'hF;
    wr_slot     = 0;
    wr_seq      = 16'd0;
    wr_off      = 0;
    wr_open     = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part with all kinds on and no idling
    run_phase(4'hF, 0, 0, 0);
    // random parts over several masks, extremes included
    run_phase(4'b1011, 55, 0, 40);
    run_phase(4'h0, 0, 55, 40);
    run_phase(4'b0110, 26, 26, 40);
    run_phase(4'hF, 0, 0, 40);

    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard: far beyond the slowest correct run, clearing sweep included
  initial begin
    #800000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sequenced_ring_log_store.f -----
hdl/slrs_pkg.sv
hdl/slrs_seq_store.sv
hdl/slrs_entry_store.sv
hdl/sequenced_ring_log_store.sv
tb/sequenced_ring_log_store_tb.sv
